// ----- hw/rtl/tpac_pkg.sv -----
// Shared types and constants for the two-point ADC calibration core.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package tpac_pkg;

   localparam int AdcFullScaleBitsDefault = 23;
   localparam int NumChannelsDefault      = 3;

   // Request codes
   localparam logic [2:0] REQ_START = 3'd0;
   localparam logic [2:0] REQ_VALUE = 3'd1;
   localparam logic [2:0] REQ_ADC   = 3'd2;
   localparam logic [2:0] REQ_ACK   = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   // Calibration phases as reported on the result channel
   localparam logic [2:0] PH_STANDBY = 3'd0;
   localparam logic [2:0] PH_WAIT1   = 3'd1;
   localparam logic [2:0] PH_WAIT2   = 3'd2;
   localparam logic [2:0] PH_UPDATE  = 3'd3;
   localparam logic [2:0] PH_FINISH  = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_REFERENCE = 2'd0;
   localparam logic [1:0] CSR_VRATIO    = 2'd1;
   localparam logic [1:0] CSR_IRATIO    = 2'd2;

   localparam logic [31:0] STORED_REF_RESET = 32'd163840;
   localparam logic [31:0] RATIO_RESET      = 32'd65536;
   localparam logic [31:0] GAIN_ONE         = 32'h1000_0000;

   // Width of the accumulator that holds the gain divisor or the offset numerator
   localparam int ACC_W = 90;
   localparam int DEN_W = ACC_W - 1;
   localparam int MUL_W = 34;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_CHECK,
      OP_MUL_RR,
      OP_KEEP_RR,
      OP_MUL_LO,
      OP_ACC_LO,
      OP_MUL_HI,
      OP_ACC_HI,
      OP_DIV_GAIN,
      OP_SAVE_GAIN,
      OP_MUL_C1DV,
      OP_ACC_C1DV,
      OP_MUL_DCV1,
      OP_ACC_DCV1,
      OP_DIV_OFF,
      OP_SAVE_OFF,
      OP_APPLY
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic upd_pending;
      logic check_fail;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/two_point_adc_calibration_core.sv -----
// Two-point ADC calibration core: one result per request.
// A plain request is latched, then written to the result register; the first request after
// a completed second sample runs the update first, unless its check fails, with two serial
// divisions of ADC_FULL_SCALE_BITS+77 quotient bits before the result is written.
// A new request is taken only after the result of the last one has been written.
// Reset (synchronous): standby, unit gains, zero offsets, 2.5 V stored reference.
`default_nettype none

module two_point_adc_calibration_core #(
   parameter int ADC_FULL_SCALE_BITS = tpac_pkg::AdcFullScaleBitsDefault,
   parameter int NUM_CHANNELS        = tpac_pkg::NumChannelsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [1:0]  req_channel,
   input  wire logic [31:0] req_applied_value,
   input  wire logic [23:0] req_adc_link,
   input  wire logic [23:0] req_adc_battery,
   input  wire logic [23:0] req_adc_current,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_cal_state,
   output logic [31:0]      rsp_gain_out,
   output logic [39:0]      rsp_offset_out,
   output logic             rsp_cal_error
);

   tpac_pkg::dp_cmd_type    cmd;
   tpac_pkg::dp_status_type status;

   tpac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tpac_dp #(
      .ADC_FULL_SCALE_BITS (ADC_FULL_SCALE_BITS),
      .NUM_CHANNELS        (NUM_CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_channel       (req_channel),
      .req_applied_value (req_applied_value),
      .req_adc_link      (req_adc_link),
      .req_adc_battery   (req_adc_battery),
      .req_adc_current   (req_adc_current),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cal_state     (rsp_cal_state),
      .rsp_gain_out      (rsp_gain_out),
      .rsp_offset_out    (rsp_offset_out),
      .rsp_cal_error     (rsp_cal_error)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/tpac_div.sv -----
// Serial restoring divider, one quotient bit per cycle, rounded half up.
// Depends on tpac_pkg for the divisor width.
`default_nettype none

module tpac_div #(
   parameter int NUM_W = 100
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [NUM_W-1:0]            num_in,
   input  wire logic [tpac_pkg::DEN_W-1:0]  den_in,
   output logic      [NUM_W-1:0]            quot,
   output logic                             done
);

   localparam int DW    = tpac_pkg::DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, q_ff;
   logic [DW-1:0]    den_ff, rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DW:0]      rem_sh, diff, rem_dbl;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      diff    = rem_sh - {1'b0, den_ff};
      rem_dbl = {rem_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= num_in;
            den_ff  <= den_in;
            rem_ff  <= '0;
            q_ff    <= '0;
            cnt_ff  <= CNT_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               rem_ff <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
               q_ff   <= {q_ff[NUM_W-2:0], ge};
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               // Round half away from zero on the magnitude.
               if (rem_dbl >= {1'b0, den_ff}) begin
                  q_ff <= q_ff + 1'b1;
               end
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tpac_dp.sv -----
// Datapath: calibration state, configuration registers, shared multiplier,
// result register and the serial divider. Depends on tpac_pkg and tpac_div.
`default_nettype none

module tpac_dp #(
   parameter int ADC_FULL_SCALE_BITS = tpac_pkg::AdcFullScaleBitsDefault,
   parameter int NUM_CHANNELS        = tpac_pkg::NumChannelsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpac_pkg::dp_cmd_type cmd,
   output tpac_pkg::dp_status_type   status,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [31:0]          csr_wdata,
   input  wire logic [2:0]           req_type,
   input  wire logic [1:0]           req_channel,
   input  wire logic [31:0]          req_applied_value,
   input  wire logic [23:0]          req_adc_link,
   input  wire logic [23:0]          req_adc_battery,
   input  wire logic [23:0]          req_adc_current,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_cal_state,
   output logic [31:0]               rsp_gain_out,
   output logic [39:0]               rsp_offset_out,
   output logic                      rsp_cal_error
);

   localparam int NUM_W  = ADC_FULL_SCALE_BITS + 77;
   localparam int GSHIFT = ADC_FULL_SCALE_BITS + 44;
   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ACC_W  = tpac_pkg::ACC_W;
   localparam int MW     = tpac_pkg::MUL_W;

   logic [31:0] ref_ff, vratio_ff, iratio_ff, stored_ref_ff;
   logic [2:0]  phase_ff;
   logic [1:0]  active_ff;
   logic        pending_ff, error_ff;
   logic [31:0] v1_ff, v2_ff;
   logic [23:0] c1_ff, c2_ff;
   logic [31:0] gain_ff   [NUM_CHANNELS];
   logic [39:0] offset_ff [NUM_CHANNELS];

   logic [2:0]  lt_type_ff;
   logic [1:0]  lt_ch_ff;
   logic [31:0] lt_value_ff;
   logic [23:0] lt_link_ff, lt_batt_ff, lt_curr_ff;

   logic signed [2*MW-1:0] prod_ff;
   logic [63:0]            rr_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic                   gneg_ff, oneg_ff;
   logic [31:0]            gnew_ff;

   logic        rsp_valid_ff, rsp_error_ff;
   logic [2:0]  rsp_state_ff;
   logic [31:0] rsp_gain_ff;
   logic [39:0] rsp_offset_ff;

   logic signed [32:0] dv;
   logic signed [24:0] dc;
   logic [32:0]        dv_mag;
   logic [24:0]        dc_mag;
   logic [31:0]        ratio, ref_sel;
   logic               volt, fail;
   logic signed [MW-1:0] mul_a, mul_b;
   logic [ACC_W-1:0]   acc_mag;
   logic [NUM_W-1:0]   div_num, quot;
   logic               div_start, div_done;
   logic               g_over, o_over;
   logic [31:0]        g_lim, g_mag, g_val;
   logic [39:0]        o_lim, o_mag, o_val;
   logic               out_free;

   assign volt    = active_ff < 2'd2;
   assign ratio   = volt ? vratio_ff : iratio_ff;
   assign ref_sel = (ref_ff != '0) ? ref_ff : stored_ref_ff;
   assign dv      = $signed({v2_ff[31], v2_ff}) - $signed({v1_ff[31], v1_ff});
   assign dc      = $signed({c2_ff[23], c2_ff}) - $signed({c1_ff[23], c1_ff});
   assign dv_mag  = dv[32] ? 33'(-dv) : 33'(dv);
   assign dc_mag  = dc[24] ? 25'(-dc) : 25'(dc);
   assign fail    = (dv == '0) || (dc == '0) || (ratio == '0) || (ref_sel == '0);
   assign acc_mag = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the one shared signed multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         tpac_pkg::OP_MUL_RR: begin
            mul_a = MW'({1'b0, ratio});
            mul_b = MW'({1'b0, ref_sel});
         end
         tpac_pkg::OP_MUL_LO: begin
            mul_a = MW'({1'b0, rr_ff[31:0]});
            mul_b = MW'({1'b0, dc_mag});
         end
         tpac_pkg::OP_MUL_HI: begin
            mul_a = MW'({1'b0, rr_ff[63:32]});
            mul_b = MW'({1'b0, dc_mag});
         end
         tpac_pkg::OP_MUL_C1DV: begin
            mul_a = MW'($signed(c1_ff));
            mul_b = MW'(dv);
         end
         tpac_pkg::OP_MUL_DCV1: begin
            mul_a = MW'(dc);
            mul_b = MW'($signed(v1_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      if (cmd.op == tpac_pkg::OP_DIV_GAIN) begin
         div_start = 1'b1;
         div_num   = NUM_W'(dv_mag) << GSHIFT;
      end else if (cmd.op == tpac_pkg::OP_DIV_OFF) begin
         div_start = 1'b1;
         div_num   = NUM_W'(acc_mag[58:0]) << 8;
      end
   end

   tpac_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_in (div_num),
      .den_in ((cmd.op == tpac_pkg::OP_DIV_GAIN) ? acc_ff[tpac_pkg::DEN_W-1:0]
                                                 : tpac_pkg::DEN_W'(dv_mag)),
      .quot   (quot),
      .done   (div_done)
   );

   // Saturation of the rounded magnitudes to the signed result formats.
   always_comb begin
      g_lim  = gneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      g_over = (|quot[NUM_W-1:32]) || (quot[31:0] > g_lim);
      g_mag  = g_over ? g_lim : quot[31:0];
      g_val  = gneg_ff ? -g_mag : g_mag;
      o_lim  = oneg_ff ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
      o_over = (|quot[NUM_W-1:40]) || (quot[39:0] > o_lim);
      o_mag  = o_over ? o_lim : quot[39:0];
      o_val  = oneg_ff ? -o_mag : o_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff        <= '0;
         vratio_ff     <= tpac_pkg::RATIO_RESET;
         iratio_ff     <= tpac_pkg::RATIO_RESET;
         stored_ref_ff <= tpac_pkg::STORED_REF_RESET;
         phase_ff      <= tpac_pkg::PH_STANDBY;
         active_ff     <= '0;
         pending_ff    <= 1'b0;
         error_ff      <= 1'b0;
         v1_ff         <= '0;
         v2_ff         <= '0;
         c1_ff         <= '0;
         c2_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            gain_ff[i]   <= tpac_pkg::GAIN_ONE;
            offset_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               tpac_pkg::CSR_REFERENCE: ref_ff    <= csr_wdata;
               tpac_pkg::CSR_VRATIO:    vratio_ff <= csr_wdata;
               tpac_pkg::CSR_IRATIO:    iratio_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (cmd.op)
            tpac_pkg::OP_LATCH: begin
               lt_type_ff  <= req_type;
               lt_ch_ff    <= req_channel;
               lt_value_ff <= req_applied_value;
               lt_link_ff  <= req_adc_link;
               lt_batt_ff  <= req_adc_battery;
               lt_curr_ff  <= req_adc_current;
            end
            tpac_pkg::OP_CHECK: begin
               if (fail) begin
                  error_ff <= 1'b1;
                  phase_ff <= tpac_pkg::PH_FINISH;
               end
            end
            tpac_pkg::OP_MUL_RR, tpac_pkg::OP_MUL_LO, tpac_pkg::OP_MUL_HI,
            tpac_pkg::OP_MUL_C1DV, tpac_pkg::OP_MUL_DCV1: begin
               prod_ff <= mul_a * mul_b;
            end
            tpac_pkg::OP_KEEP_RR: rr_ff <= prod_ff[63:0];
            tpac_pkg::OP_ACC_LO:  acc_ff <= ACC_W'(prod_ff[63:0]);
            tpac_pkg::OP_ACC_HI:  acc_ff <= acc_ff + (ACC_W'(prod_ff[57:0]) << 32);
            tpac_pkg::OP_DIV_GAIN: gneg_ff <= (dv[32] != dc[24]) != volt;
            tpac_pkg::OP_SAVE_GAIN: gnew_ff <= g_val;
            tpac_pkg::OP_ACC_C1DV: acc_ff <= ACC_W'(prod_ff);
            tpac_pkg::OP_ACC_DCV1: acc_ff <= acc_ff - ACC_W'(prod_ff);
            tpac_pkg::OP_DIV_OFF: oneg_ff <= acc_ff[ACC_W-1] != dv[32];
            tpac_pkg::OP_SAVE_OFF: begin
               gain_ff[active_ff[IDX_W-1:0]]   <= gnew_ff;
               offset_ff[active_ff[IDX_W-1:0]] <= o_val;
               error_ff      <= 1'b0;
               stored_ref_ff <= ref_sel;
               phase_ff      <= tpac_pkg::PH_FINISH;
            end
            tpac_pkg::OP_APPLY: begin
               automatic logic [2:0]  ph  = phase_ff;
               automatic logic [1:0]  rep = active_ff;
               automatic logic [23:0] code;
               case (active_ff)
                  2'd0:    code = lt_batt_ff;
                  2'd1:    code = lt_link_ff;
                  default: code = lt_curr_ff;
               endcase
               case (lt_type_ff)
                  tpac_pkg::REQ_START: begin
                     if (32'(lt_ch_ff) < NUM_CHANNELS) begin
                        ph         = tpac_pkg::PH_WAIT1;
                        active_ff  <= lt_ch_ff;
                        pending_ff <= 1'b0;
                        rep        = lt_ch_ff;
                     end
                  end
                  tpac_pkg::REQ_VALUE: begin
                     if (phase_ff == tpac_pkg::PH_WAIT1) v1_ff <= lt_value_ff;
                     else if (phase_ff == tpac_pkg::PH_WAIT2) v2_ff <= lt_value_ff;
                     pending_ff <= 1'b1;
                  end
                  tpac_pkg::REQ_ADC: begin
                     if (pending_ff && phase_ff == tpac_pkg::PH_WAIT1) begin
                        c1_ff      <= code;
                        ph         = tpac_pkg::PH_WAIT2;
                        pending_ff <= 1'b0;
                     end else if (pending_ff && phase_ff == tpac_pkg::PH_WAIT2) begin
                        c2_ff      <= code;
                        ph         = tpac_pkg::PH_UPDATE;
                        pending_ff <= 1'b0;
                     end
                  end
                  tpac_pkg::REQ_ACK: begin
                     if (phase_ff == tpac_pkg::PH_FINISH) ph = tpac_pkg::PH_STANDBY;
                  end
                  default: ;
               endcase
               phase_ff     <= ph;
               rsp_state_ff <= ph;
               rsp_error_ff <= error_ff;
               rsp_valid_ff <= 1'b1;
               if (lt_type_ff == tpac_pkg::REQ_READ) begin
                  if (32'(lt_ch_ff) < NUM_CHANNELS) begin
                     rsp_gain_ff   <= gain_ff[lt_ch_ff[IDX_W-1:0]];
                     rsp_offset_ff <= offset_ff[lt_ch_ff[IDX_W-1:0]];
                  end else begin
                     rsp_gain_ff   <= '0;
                     rsp_offset_ff <= '0;
                  end
               end else begin
                  rsp_gain_ff   <= gain_ff[rep[IDX_W-1:0]];
                  rsp_offset_ff <= offset_ff[rep[IDX_W-1:0]];
               end
            end
            default: ;
         endcase
      end
   end

   assign status.upd_pending = phase_ff == tpac_pkg::PH_UPDATE;
   assign status.check_fail  = fail;
   assign status.div_done    = div_done;
   assign status.out_free    = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cal_state  = rsp_state_ff;
   assign rsp_gain_out   = rsp_gain_ff;
   assign rsp_offset_out = rsp_offset_ff;
   assign rsp_cal_error  = rsp_error_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tpac_ctrl.sv -----
// Controller: steps the datapath through request capture, the update
// sequence and result write-back. Depends on tpac_pkg.
`default_nettype none

module tpac_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tpac_pkg::dp_status_type status,
   output tpac_pkg::dp_cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_MUL_RR, S_KEEP_RR, S_MUL_LO, S_ACC_LO, S_MUL_HI,
      S_ACC_HI, S_DIV_G, S_WAIT_G, S_SAVE_G, S_MUL_A, S_ACC_A, S_MUL_B,
      S_ACC_B, S_DIV_O, S_WAIT_O, S_SAVE_O, S_APPLY
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = tpac_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = tpac_pkg::OP_LATCH;
               state_in = status.upd_pending ? S_CHECK : S_APPLY;
            end
         end
         S_CHECK: begin
            cmd.op   = tpac_pkg::OP_CHECK;
            state_in = status.check_fail ? S_APPLY : S_MUL_RR;
         end
         S_MUL_RR:  begin cmd.op = tpac_pkg::OP_MUL_RR;   state_in = S_KEEP_RR; end
         S_KEEP_RR: begin cmd.op = tpac_pkg::OP_KEEP_RR;  state_in = S_MUL_LO;  end
         S_MUL_LO:  begin cmd.op = tpac_pkg::OP_MUL_LO;   state_in = S_ACC_LO;  end
         S_ACC_LO:  begin cmd.op = tpac_pkg::OP_ACC_LO;   state_in = S_MUL_HI;  end
         S_MUL_HI:  begin cmd.op = tpac_pkg::OP_MUL_HI;   state_in = S_ACC_HI;  end
         S_ACC_HI:  begin cmd.op = tpac_pkg::OP_ACC_HI;   state_in = S_DIV_G;   end
         S_DIV_G:   begin cmd.op = tpac_pkg::OP_DIV_GAIN; state_in = S_WAIT_G;  end
         S_WAIT_G: begin
            if (status.div_done) state_in = S_SAVE_G;
         end
         S_SAVE_G:  begin cmd.op = tpac_pkg::OP_SAVE_GAIN; state_in = S_MUL_A; end
         S_MUL_A:   begin cmd.op = tpac_pkg::OP_MUL_C1DV;  state_in = S_ACC_A; end
         S_ACC_A:   begin cmd.op = tpac_pkg::OP_ACC_C1DV;  state_in = S_MUL_B; end
         S_MUL_B:   begin cmd.op = tpac_pkg::OP_MUL_DCV1;  state_in = S_ACC_B; end
         S_ACC_B:   begin cmd.op = tpac_pkg::OP_ACC_DCV1;  state_in = S_DIV_O; end
         S_DIV_O:   begin cmd.op = tpac_pkg::OP_DIV_OFF;   state_in = S_WAIT_O; end
         S_WAIT_O: begin
            if (status.div_done) state_in = S_SAVE_O;
         end
         S_SAVE_O:  begin cmd.op = tpac_pkg::OP_SAVE_OFF;  state_in = S_APPLY; end
         S_APPLY: begin
            // The result register must be free or emptying in this cycle.
            if (status.out_free) begin
               cmd.op   = tpac_pkg::OP_APPLY;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for two_point_adc_calibration_core.
// Depends on tpac_pkg; predicts every result in a small scoreboard class.
`default_nettype none

module tb;

   localparam logic [2:0] REQ_UNUSED = 3'd7;
   localparam int         IDLE_LIMIT = 5000;
   localparam int         SETTLE     = 400;

   typedef struct packed {
      logic [2:0]  state;
      logic [31:0] gain;
      logic [39:0] offset;
      logic        err;
   } cal_result_type;

   class cal_scoreboard_type;
      logic [31:0] reference, vratio, iratio, stored_ref;
      logic [2:0]  phase;
      logic [1:0]  active_ch;
      logic        pending, err_flag;
      logic [31:0] val1, val2;
      logic [23:0] code1, code2;
      logic [31:0] gains[3];
      logic [39:0] offsets[3];
      cal_result_type awaited[$];
      int          errors;

      function new();
         reference  = 0;
         vratio     = tpac_pkg::RATIO_RESET;
         iratio     = tpac_pkg::RATIO_RESET;
         stored_ref = tpac_pkg::STORED_REF_RESET;
         phase      = tpac_pkg::PH_STANDBY;
         active_ch  = 0;
         pending    = 0;
         err_flag   = 0;
         val1 = 0; val2 = 0; code1 = 0; code2 = 0;
         for (int i = 0; i < 3; i++) begin
            gains[i]   = tpac_pkg::GAIN_ONE;
            offsets[i] = 0;
         end
         errors = 0;
      endfunction

      function void write_csr(logic [1:0] idx, logic [31:0] data);
         case (idx)
            tpac_pkg::CSR_REFERENCE: reference = data;
            tpac_pkg::CSR_VRATIO:    vratio    = data;
            tpac_pkg::CSR_IRATIO:    iratio    = data;
            default: ;
         endcase
      endfunction

      function logic [63:0] magnitude(longint v);
         return v < 0 ? -v : v;
      endfunction

      // Rounded quotient, half away from zero, on magnitudes.
      function logic [127:0] round_div(logic [127:0] num, logic [127:0] den);
         logic [127:0] q, r;
         q = num / den;
         r = num % den;
         if ((r << 1) >= den) q = q + 1;
         return q;
      endfunction

      function logic [63:0] saturate(logic [127:0] mag, logic neg, int bits);
         logic [63:0] lim, m;
         lim = 64'd1 << (bits - 1);
         if (!neg) lim = lim - 1;
         m = (mag > {64'd0, lim}) ? lim : mag[63:0];
         return neg ? -m : m;
      endfunction

      function void run_update();
         longint      v1, v2, c1, c2, dv, dc, on;
         logic        volt, neg;
         logic [31:0] ratio, refv;
         logic [127:0] num, den;
         v1 = longint'($signed(val1));
         v2 = longint'($signed(val2));
         c1 = longint'($signed(code1));
         c2 = longint'($signed(code2));
         dv = v2 - v1;
         dc = c2 - c1;
         volt  = active_ch < 2;
         ratio = volt ? vratio : iratio;
         refv  = reference != 0 ? reference : stored_ref;
         if (dv == 0 || dc == 0 || ratio == 0 || refv == 0) begin
            err_flag = 1;
            return;
         end
         err_flag   = 0;
         stored_ref = refv;
         num = {64'd0, magnitude(dv)} << (tpac_pkg::AdcFullScaleBitsDefault + 44);
         den = {64'd0, 64'(ratio) * 64'(refv)} * {64'd0, magnitude(dc)};
         neg = ((dv < 0) != (dc < 0)) != volt;
         gains[active_ch] = 32'(saturate(round_div(num, den), neg, 32));
         on  = c1 * dv - dc * v1;
         num = {64'd0, magnitude(on)} << 8;
         den = {64'd0, magnitude(dv)};
         neg = (on < 0) != (dv < 0);
         offsets[active_ch] = 40'(saturate(round_div(num, den), neg, 40));
      endfunction

      function void note_request(logic [2:0] kind, logic [1:0] ch, logic [31:0] applied,
                                 logic [23:0] link, logic [23:0] bat, logic [23:0] cur);
         logic [1:0]  rep;
         logic [23:0] code;
         cal_result_type res;
         rep = active_ch;
         if (phase == tpac_pkg::PH_UPDATE) begin
            run_update();
            phase = tpac_pkg::PH_FINISH;
         end
         case (kind)
            tpac_pkg::REQ_START: if (ch < 3) begin
               phase = tpac_pkg::PH_WAIT1;
               active_ch = ch;
               pending = 0;
               rep = ch;
            end
            tpac_pkg::REQ_VALUE: begin
               if (phase == tpac_pkg::PH_WAIT1) val1 = applied;
               else if (phase == tpac_pkg::PH_WAIT2) val2 = applied;
               pending = 1;
            end
            tpac_pkg::REQ_ADC: begin
               code = active_ch == 0 ? bat : (active_ch == 1 ? link : cur);
               if (pending && phase == tpac_pkg::PH_WAIT1) begin
                  code1 = code;
                  phase = tpac_pkg::PH_WAIT2;
                  pending = 0;
               end else if (pending && phase == tpac_pkg::PH_WAIT2) begin
                  code2 = code;
                  phase = tpac_pkg::PH_UPDATE;
                  pending = 0;
               end
            end
            tpac_pkg::REQ_ACK:
               if (phase == tpac_pkg::PH_FINISH) phase = tpac_pkg::PH_STANDBY;
            default: ;
         endcase
         res.state = phase;
         if (kind == tpac_pkg::REQ_READ) begin
            res.gain   = ch < 3 ? gains[ch] : 32'd0;
            res.offset = ch < 3 ? offsets[ch] : 40'd0;
         end else begin
            res.gain   = gains[rep];
            res.offset = offsets[rep];
         end
         res.err = err_flag;
         awaited.push_back(res);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_result(cal_result_type got);
         cal_result_type exp_r;
         if (awaited.size() == 0) begin
            report("result transfer with nothing outstanding");
            return;
         end
         exp_r = awaited.pop_front();
         if (got.state !== exp_r.state)
            report($sformatf("cal_state %0d, predicted %0d", got.state, exp_r.state));
         if (got.gain !== exp_r.gain)
            report($sformatf("gain_out %h, predicted %h", got.gain, exp_r.gain));
         if (got.offset !== exp_r.offset)
            report($sformatf("offset_out %h, predicted %h", got.offset, exp_r.offset));
         if (got.err !== exp_r.err)
            report($sformatf("cal_error %0b, predicted %0b", got.err, exp_r.err));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_type = 0;
   logic [1:0]  req_channel = 0;
   logic [31:0] req_applied_value = 0;
   logic [23:0] req_adc_link = 0;
   logic [23:0] req_adc_battery = 0;
   logic [23:0] req_adc_current = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_cal_state;
   logic [31:0] rsp_gain_out;
   logic [39:0] rsp_offset_out;
   logic        rsp_cal_error;

   cal_scoreboard_type sb = new();
   logic hold_off = 0;
   logic quiet = 0;
   int   idle_cycles = 0;

   two_point_adc_calibration_core DUT (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_type, .req_channel, .req_applied_value,
      .req_adc_link, .req_adc_battery, .req_adc_current,
      .rsp_valid, .rsp_stall, .rsp_cal_state, .rsp_gain_out, .rsp_offset_out,
      .rsp_cal_error
   );

   always #5 clock = ~clock;

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int run;
      run = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
            run = 0;
         end else if (run > 0) begin
            run--;
         end else if (quiet) begin
            rsp_stall = 0;
         end else begin
            rsp_stall = ~rsp_stall;
            run = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_cal_state, rsp_gain_out, rsp_offset_out, rsp_cal_error});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task send(logic [2:0] kind, logic [1:0] ch, logic [31:0] applied,
             logic [23:0] link, logic [23:0] bat, logic [23:0] cur);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_type = kind;
      req_channel = ch;
      req_applied_value = applied;
      req_adc_link = link;
      req_adc_battery = bat;
      req_adc_current = cur;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, ch, applied, link, bat, cur);
      @(negedge clock);
   endtask

   task send_simple(logic [2:0] kind, logic [1:0] ch);
      send(kind, ch, $urandom, 24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   // Places the code on the port the active channel samples, noise elsewhere.
   task send_code(logic [1:0] ch, logic [23:0] code);
      send(tpac_pkg::REQ_ADC, 2'($urandom), $urandom, ch == 1 ? code : 24'($urandom),
           ch == 0 ? code : 24'($urandom), ch == 2 ? code : 24'($urandom));
   endtask

   task calibrate(logic [1:0] ch, logic [31:0] v1, logic [23:0] c1,
                  logic [31:0] v2, logic [23:0] c2);
      send_simple(tpac_pkg::REQ_START, ch);
      send(tpac_pkg::REQ_VALUE, 2'($urandom), v1, 24'($urandom), 24'($urandom),
           24'($urandom));
      send_code(ch, c1);
      send(tpac_pkg::REQ_VALUE, 2'($urandom), v2, 24'($urandom), 24'($urandom),
           24'($urandom));
      send_code(ch, c2);
   endtask

   task drain();
      req_valid = 0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [31:0] data);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_csr(idx, data);
      @(negedge clock);
      csr_we = 0;
   endtask

   task random_sequence();
      logic [1:0]  ch;
      logic [31:0] v1, v2;
      logic [23:0] c1, c2;
      int          r;
      r  = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 2));
      v1 = $urandom;
      v2 = ($urandom_range(0, 3) == 0) ? v1 + $urandom_range(0, 4096) : $urandom;
      c1 = 24'($urandom);
      c2 = ($urandom_range(0, 3) == 0) ? c1 + 24'($urandom_range(0, 64)) : 24'($urandom);
      if (r < 8) v2 = v1;
      else if (r < 14) c2 = c1;
      if (r < 80) begin
         calibrate(ch, v1, c1, v2, c2);
         if ($urandom_range(0, 2) != 0) send_simple(tpac_pkg::REQ_READ, 2'($urandom));
         if ($urandom_range(0, 3) != 0) send_simple(tpac_pkg::REQ_ACK, 2'($urandom));
      end else begin
         // Noise and broken sequences.
         repeat ($urandom_range(1, 6)) send_simple(3'($urandom), 2'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part.
      send_simple(tpac_pkg::REQ_READ, 0);
      send_simple(tpac_pkg::REQ_READ, 3);
      send_simple(tpac_pkg::REQ_START, 3);
      send_simple(tpac_pkg::REQ_VALUE, 1);
      send_simple(tpac_pkg::REQ_ADC, 2);
      send_simple(tpac_pkg::REQ_ACK, 0);
      send_simple(REQ_UNUSED, 2);
      calibrate(0, 32'h8000_0000, 24'h80_0000, 32'h7fff_ffff, 24'h7f_ffff);
      send_simple(tpac_pkg::REQ_READ, 0);
      send_simple(tpac_pkg::REQ_ACK, 1);
      calibrate(1, 32'h0001_0000, 24'h00_1000, 32'h0001_0000, 24'h00_2000);
      send_simple(tpac_pkg::REQ_READ, 1);
      calibrate(2, 32'h0000_0000, 24'h00_0100, 32'h0002_0000, 24'h00_0100);
      send_simple(tpac_pkg::REQ_ACK, 2);
      drain();

      // Register settings, extremes first, then the reset values, then random ones.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(tpac_pkg::CSR_REFERENCE, 32'hffff_ffff);
               write_reg(tpac_pkg::CSR_VRATIO, 32'd1);
               write_reg(tpac_pkg::CSR_IRATIO, 32'hffff_ffff); end
            1: begin write_reg(tpac_pkg::CSR_REFERENCE, 32'd1);
               write_reg(tpac_pkg::CSR_VRATIO, 32'hffff_ffff);
               write_reg(tpac_pkg::CSR_IRATIO, 32'd1); end
            2: begin write_reg(tpac_pkg::CSR_REFERENCE, 32'd0);
               write_reg(tpac_pkg::CSR_VRATIO, tpac_pkg::RATIO_RESET);
               write_reg(tpac_pkg::CSR_IRATIO, tpac_pkg::RATIO_RESET); end
            default: begin
               write_reg(tpac_pkg::CSR_REFERENCE, $urandom_range(0, 3) == 0 ? 0 : $urandom);
               write_reg(tpac_pkg::CSR_VRATIO, $urandom_range(1, 32'h0010_0000));
               write_reg(tpac_pkg::CSR_IRATIO, $urandom_range(1, 32'hffff_ffff));
            end
         endcase
         quiet = (ph == 4);
         if (ph == 5) hold_off = 1;
         for (int n = 0; n < 16; n++) begin
            random_sequence();
            if (n == 7 && ph == 6) begin
               // Sender waits for every outstanding result before going on.
               req_valid = 0;
               while (sb.awaited.size() != 0) @(negedge clock);
            end
         end
         drain();
      end

      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/tpac_pkg.sv
hw/rtl/tpac_div.sv
hw/rtl/tpac_dp.sv
hw/rtl/tpac_ctrl.sv
hw/rtl/two_point_adc_calibration_core.sv
tb/tb.sv
